>>> hw/rtl/sbft_pkg.sv
`default_nettype none

package sbft_pkg;

    localparam int COORD_W    = 8;
    localparam int ROW_W      = 9;
    localparam int PIXEL_W    = 8;
    localparam int COLOR_W    = 4;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_BYTE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPRITE_HEIGHT = 3'd4;

    localparam logic [COLOR_W-1:0] FLIP_H    = 4'd1;
    localparam logic [COLOR_W-1:0] FLIP_V    = 4'd2;
    localparam logic [COLOR_W-1:0] FLIP_BOTH = 4'd3;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 8'd8;

    localparam logic MODE_DRAW  = 1'b0;
    localparam logic MODE_ERASE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0]    origin_x;
        logic [COORD_W-1:0]    origin_y;
        logic [CFG_DATA_W-1:0] colour_byte;
        logic [COORD_W-1:0]    sprite_width;
        logic [COORD_W-1:0]    sprite_height;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } pos_t;

    typedef struct packed {
        logic               mode;
        logic [PIXEL_W-1:0] pixel_value;
        pos_t               pos;
    } stage_t;

    typedef struct packed {
        logic [COORD_W-1:0] pix_x;
        logic [ROW_W-1:0]   pix_y;
        logic [COLOR_W-1:0] pix_data;
        logic               write_enable;
        logic               last;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbft_if.sv
`default_nettype none

interface sbft_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [sbft_pkg::PIXEL_W-1:0]  pixel_value;

    modport source (output valid, output mode, output pixel_value, input ready);
    modport sink (input valid, input mode, input pixel_value, output ready);
endinterface

interface sbft_out_if;
    logic                          valid;
    logic                          ready;
    logic [sbft_pkg::COORD_W-1:0]  pix_x;
    logic [sbft_pkg::ROW_W-1:0]    pix_y;
    logic [sbft_pkg::COLOR_W-1:0]  pix_data;
    logic                          write_enable;
    logic                          last;

    modport source (
        output valid, output pix_x, output pix_y, output pix_data,
        output write_enable, output last, input ready
    );
    modport sink (
        input valid, input pix_x, input pix_y, input pix_data,
        input write_enable, input last, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/sbft_cnt.sv
`default_nettype none

module sbft_cnt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  sbft_pkg::cfg_t cfg,
    output sbft_pkg::pos_t pos
);
    import sbft_pkg::*;

    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] wmax;
    logic [COORD_W-1:0] hmax;
    logic               col_end;
    logic               row_end;

    // A size of zero acts as 256, which the 8-bit wrap of the subtraction gives.
    assign wmax    = cfg.sprite_width - COORD_W'(1);
    assign hmax    = cfg.sprite_height - COORD_W'(1);
    assign col_end = col_reg >= wmax;
    assign row_end = row_reg >= hmax;

    always_comb
    begin
        col_next = col_reg + COORD_W'(1);
        row_next = row_reg;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + COORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col  = col_reg;
    assign pos.row  = row_reg;
    assign pos.last = col_end && row_end;

endmodule

`default_nettype wire

>>> hw/rtl/sbft_calc.sv
`default_nettype none

module sbft_calc (
    input  logic                stage_valid,
    input  sbft_pkg::stage_t    stage,
    input  sbft_pkg::cfg_t      cfg,
    output sbft_pkg::out_item_t result,
    output logic                result_valid
);
    import sbft_pkg::*;

    logic [COLOR_W-1:0]   flip;
    logic                 flip_h;
    logic                 flip_v;
    logic [COORD_W-1:0]   wmax;
    logic [COORD_W-1:0]   hmax;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   ry;
    logic [2*PIXEL_W-1:0] prod_full;
    logic [PIXEL_W-1:0]   prod;

    assign flip      = cfg.colour_byte[CFG_DATA_W-1 -: COLOR_W];
    assign flip_h    = (flip == FLIP_H) || (flip == FLIP_BOTH);
    assign flip_v    = (flip == FLIP_V) || (flip == FLIP_BOTH);
    assign wmax      = cfg.sprite_width - COORD_W'(1);
    assign hmax      = cfg.sprite_height - COORD_W'(1);
    assign cx        = flip_h ? wmax - stage.pos.col : stage.pos.col;
    assign ry        = flip_v ? hmax - stage.pos.row : stage.pos.row;
    assign prod_full = (2*PIXEL_W)'(stage.pixel_value) * (2*PIXEL_W)'(cfg.colour_byte);
    assign prod      = prod_full[PIXEL_W-1:0];

    always_comb
    begin
        result.last = stage.pos.last;
        if (stage.mode == MODE_ERASE)
        begin
            // Erase writes at the unflipped position and the row is not wrapped.
            result.pix_x        = cfg.origin_x + stage.pos.col;
            result.pix_y        = {1'b0, cfg.origin_y} + {1'b0, stage.pos.row};
            result.pix_data     = '0;
            result.write_enable = 1'b1;
        end
        else
        begin
            result.pix_x        = cfg.origin_x + cx;
            result.pix_y        = {1'b0, cfg.origin_y + ry};
            result.pix_data     = prod[COLOR_W-1:0];
            result.write_enable = prod != '0;
        end
    end

    assign result_valid = stage_valid;

endmodule

`default_nettype wire

>>> hw/rtl/sprite_blit_flip_transparent.sv
// An accepted input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the input register and the result register
// advance together, so a full pipeline keeps streaming while pixel_out is ready.
// Reset: origin and color byte clear to zero, width and height to 8, the column and row
// counters to zero, and both pipeline stages empty.
`default_nettype none

module sprite_blit_flip_transparent (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sbft_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbft_pkg::CFG_DATA_W-1:0]    cfg_data,
    sbft_in_if.sink                            sprite_in,
    sbft_out_if.source                         pixel_out
);
    import sbft_pkg::*;

    cfg_t      cfg_reg;
    pos_t      pos;
    stage_t    stage_reg;
    logic      stage_valid_reg;
    out_item_t result;
    logic      result_valid;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      in_fire;
    logic      out_adv;
    logic      stage_adv;

    assign out_adv         = !out_valid_reg || pixel_out.ready;
    assign stage_adv       = !stage_valid_reg || out_adv;
    assign sprite_in.ready = stage_adv;
    assign in_fire         = sprite_in.valid && stage_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.colour_byte   <= '0;
            cfg_reg.sprite_width  <= SIZE_RESET;
            cfg_reg.sprite_height <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data;
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data;
                REG_COLOUR_BYTE:   cfg_reg.colour_byte   <= cfg_data;
                REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data;
                REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data;
                default:           ;
            endcase
        end
    end

    sbft_cnt u_cnt (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .cfg     (cfg_reg),
        .pos     (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (stage_adv)
            begin
                stage_valid_reg <= sprite_in.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= result_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg.mode        <= sprite_in.mode;
            stage_reg.pixel_value <= sprite_in.pixel_value;
            stage_reg.pos         <= pos;
        end
        if (result_valid && out_adv)
        begin
            out_reg <= result;
        end
    end

    sbft_calc u_calc (
        .stage_valid  (stage_valid_reg),
        .stage        (stage_reg),
        .cfg          (cfg_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.pix_x        = out_reg.pix_x;
    assign pixel_out.pix_y        = out_reg.pix_y;
    assign pixel_out.pix_data     = out_reg.pix_data;
    assign pixel_out.write_enable = out_reg.write_enable;
    assign pixel_out.last         = out_reg.last;

    // The counters wrap to the first pixel after the last pixel of the sprite.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && pos.last |=> pos.col == '0 && pos.row == '0)
        else $error("counters did not wrap after the last pixel");

    // A stalled result stage must hold the item waiting in the input stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !out_adv |=> stage_valid_reg && $stable(stage_reg))
        else $error("input stage lost an item during a stall");

    // A skipped write only comes from a draw, so it has an 8-bit row and no color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.write_enable |-> !out_reg.pix_y[ROW_W-1]
            && out_reg.pix_data == '0)
        else $error("transparent result carries erase row or color data");

endmodule

`default_nettype wire
